// ===== sv/gcf_pkg.sv =====
// shared types and constants of the gipps speed block
`default_nettype none
package gcf_pkg;

    localparam int SPEED_W         = 15;
    localparam int SPEED_FRAC_BITS = 8;
    localparam int NEXT_SPEED_W    = 7;

    localparam int ACCEL_W  = 12;
    localparam int LENGTH_W = 8;
    localparam int MARGIN_W = 10;
    localparam int BM_W     = ACCEL_W + MARGIN_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EST_BRAKE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_BRAKE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN     = 3'd4;

    localparam logic [ACCEL_W-1:0]  ACCEL_RESET     = 12'd435;
    localparam logic [ACCEL_W-1:0]  EST_BRAKE_RESET = 12'd768;
    localparam logic [ACCEL_W-1:0]  OWN_BRAKE_RESET = 12'd717;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET    = 8'd7;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET    = 10'd256;

    // divider lanes: one quotient bit per cell
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 15;
    localparam int DIV_STEPS = DIV_NUM_W;

    // 0.025 in q.16
    localparam logic [15:0] SQRT_OFFSET = 16'd1638;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] quo;
    } div_lane_t;

endpackage
`default_nettype wire

// ===== sv/gcf_if.sv =====
// valid/ready channels for vehicle records and speed results
`default_nettype none
interface gcf_vehicle_if #(parameter int POSITION_BITS = 20);
    import gcf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] own_position;
    logic [SPEED_W-1:0]       own_speed;
    logic [POSITION_BITS-1:0] leader_position;
    logic [SPEED_W-1:0]       leader_speed;
    logic [SPEED_W-1:0]       speed_limit;
    modport source (output valid, own_position, own_speed, leader_position, leader_speed,
                    speed_limit, input ready);
    modport sink (input valid, own_position, own_speed, leader_position, leader_speed,
                  speed_limit, output ready);
endinterface

interface gcf_result_if #(parameter int POSITION_BITS = 20);
    import gcf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [NEXT_SPEED_W-1:0]  new_speed;
    logic [POSITION_BITS-1:0] next_position;
    modport source (output valid, new_speed, next_position, input ready);
    modport sink (input valid, new_speed, next_position, output ready);
endinterface
`default_nettype wire

// ===== sv/gcf_div_cell.sv =====
// one restoring division step, registered
`default_nettype none
module gcf_div_cell (
    input  logic              clk,
    input  logic              en,
    input  gcf_pkg::div_lane_t lane_in,
    output gcf_pkg::div_lane_t lane_out
);
    import gcf_pkg::*;

    logic [DIV_DEN_W:0] rem_sh;
    logic [DIV_DEN_W:0] diff;
    div_lane_t          lane_next;
    div_lane_t          lane_reg;

    always_comb
    begin
        rem_sh        = {lane_in.rem, lane_in.num[DIV_NUM_W-1]};
        diff          = rem_sh - {1'b0, lane_in.den};
        lane_next.num = {lane_in.num[DIV_NUM_W-2:0], 1'b0};
        lane_next.den = lane_in.den;
        if (rem_sh >= {1'b0, lane_in.den})
        begin
            lane_next.rem = diff[DIV_DEN_W-1:0];
            lane_next.quo = {lane_in.quo[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem = rem_sh[DIV_DEN_W-1:0];
            lane_next.quo = {lane_in.quo[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

// ===== sv/gcf_sqrt_cell.sv =====
// one integer square root step (two radicand bits), registered
`default_nettype none
module gcf_sqrt_cell #(
    parameter int ARG_W = 54
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [ARG_W-1:0]     arg_in,
    input  logic [ARG_W/2-1:0]   root_in,
    input  logic [ARG_W/2:0]     rem_in,
    output logic [ARG_W-1:0]     arg_out,
    output logic [ARG_W/2-1:0]   root_out,
    output logic [ARG_W/2:0]     rem_out
);
    localparam int ROOT_W = ARG_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic [ARG_W-1:0]  arg_next, arg_reg;
    logic [ROOT_W-1:0] root_next, root_reg;
    logic [REM_W-1:0]  rem_next, rem_reg;

    always_comb
    begin
        rem_sh   = {rem_in, arg_in[ARG_W-1:ARG_W-2]};
        trial    = (REM_W+2)'({root_in, 2'b01});
        diff     = rem_sh - trial;
        arg_next = {arg_in[ARG_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            rem_next  = diff[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg  <= arg_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign arg_out  = arg_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule
`default_nettype wire

// ===== sv/gipps_car_following_speed.sv =====
// gipps car-following next speed and position, one vehicle per cycle unless stalled
//
//  channel   dir  handshake      payload
//  vehicle   in   valid/ready    own/leader position and speed, speed_limit
//  result    out  valid/ready    new_speed, next_position
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// one vehicle per cycle unless a result beat stalls; the chain is 38 divider cells, the
// radicand register, POSITION_BITS-dependent sqrt cells (27 at 20 bits), then the m1,
// m2 and output registers; the divider and square root chains are most of it
// a stalled result beat freezes the whole chain; vehicle.ready follows it
// reset clears the valid bits and loads the register defaults
`default_nettype none
module gipps_car_following_speed #(
    parameter int POSITION_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gcf_vehicle_if.sink                    vehicle,
    gcf_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [gcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gcf_pkg::*;

    localparam int PB          = POSITION_BITS;
    localparam int S_W         = PB + 1;
    localparam int INNER_W     = (PB + 21 > 41) ? PB + 21 : 41;
    localparam int X_W         = INNER_W + 14;
    localparam int XU_W        = X_W - 1;
    localparam int SQ_ARG_W0   = (XU_W > 48) ? XU_W : 48;
    localparam int SQ_ARG_W    = SQ_ARG_W0 + (SQ_ARG_W0 % 2);
    localparam int SQ_ROOT_W   = SQ_ARG_W / 2;
    localparam int SQ_REM_W    = SQ_ROOT_W + 1;
    localparam int SQ_STEPS    = SQ_ROOT_W;
    localparam int VC_W        = SQ_ROOT_W + 6;
    localparam int PREP        = DIV_STEPS;
    localparam int ST_M1       = PREP + SQ_STEPS + 1;
    localparam int ST_M2       = ST_M1 + 1;
    localparam int ST_OUT      = ST_M2 + 1;
    localparam int N_STG       = ST_OUT + 1;

    // configuration
    logic [ACCEL_W-1:0]  accel_reg, est_brake_reg, own_brake_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [BM_W-1:0]     bm_reg;
    logic [35:0]         bm2_reg;
    logic [ACCEL_W+2:0]  a5_reg;
    logic [2*BM_W-1:0]   bm_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= ACCEL_RESET;
            est_brake_reg <= EST_BRAKE_RESET;
            own_brake_reg <= OWN_BRAKE_RESET;
            length_reg    <= LENGTH_RESET;
            margin_reg    <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEL:     accel_reg     <= cfg_data;
                CFG_EST_BRAKE: est_brake_reg <= cfg_data;
                CFG_OWN_BRAKE: own_brake_reg <= cfg_data;
                CFG_LENGTH:    length_reg    <= cfg_data[LENGTH_W-1:0];
                CFG_MARGIN:    margin_reg    <= cfg_data[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // derived constants settle long before an item reaches the stages that use them
    assign bm_sq = bm_reg * bm_reg;

    always_ff @(posedge clk)
    begin
        bm_reg  <= BM_W'(est_brake_reg) * BM_W'(margin_reg);
        bm2_reg <= bm_sq[43:8];
        a5_reg  <= (ACCEL_W+3)'(accel_reg) * (ACCEL_W+3)'(5);
    end

    // pipeline control
    logic             adv;
    logic [N_STG-1:0] vld_reg, vld_next;

    assign adv           = !vld_reg[ST_OUT] || result.ready;
    assign vehicle.ready = adv;
    assign vld_next      = {vld_reg[N_STG-2:0], vehicle.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // entry
    logic [SPEED_W-1:0]   vm_fix;
    logic [ACCEL_W-1:0]   b0_fix;
    logic [2*SPEED_W-1:0] vl_sq;
    logic [PB:0]          pos_sum;
    logic [PB-1:0]        npos_in;
    logic signed [S_W-1:0] s_in;
    div_lane_t            div_f [0:DIV_STEPS];
    div_lane_t            div_c [0:DIV_STEPS];

    always_comb
    begin
        vm_fix  = (vehicle.speed_limit == '0) ? SPEED_W'(1) : vehicle.speed_limit;
        b0_fix  = (own_brake_reg == '0) ? ACCEL_W'(1) : own_brake_reg;
        vl_sq   = (2*SPEED_W)'(vehicle.leader_speed) * (2*SPEED_W)'(vehicle.leader_speed);
        pos_sum = {1'b0, vehicle.own_position}
                + (PB+1)'(vehicle.own_speed[SPEED_W-1:SPEED_FRAC_BITS]);
        npos_in = pos_sum[PB] ? {PB{1'b1}} : pos_sum[PB-1:0];
        s_in    = $signed({1'b0, vehicle.leader_position})
                - $signed({1'b0, vehicle.own_position});
    end

    // v / vmax in q.16
    assign div_f[0].num = DIV_NUM_W'({vehicle.own_speed, 16'b0});
    assign div_f[0].den = vm_fix;
    assign div_f[0].rem = '0;
    assign div_f[0].quo = '0;
    // vl^2 / b0, already scaled down to q.16
    assign div_c[0].num = DIV_NUM_W'({vl_sq, 8'b0});
    assign div_c[0].den = DIV_DEN_W'(b0_fix);
    assign div_c[0].rem = '0;
    assign div_c[0].quo = '0;

    // divider chain
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        gcf_div_cell u_div_f (.clk(clk), .en(adv), .lane_in(div_f[k]), .lane_out(div_f[k+1]));
        gcf_div_cell u_div_c (.clk(clk), .en(adv), .lane_in(div_c[k]), .lane_out(div_c[k+1]));
    end

    logic [SPEED_W-1:0]    dv_reg    [0:DIV_STEPS-1];
    logic [PB-1:0]         dnpos_reg [0:DIV_STEPS-1];
    logic signed [S_W-1:0] ds_reg    [0:DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0]    <= vehicle.own_speed;
            dnpos_reg[0] <= npos_in;
            ds_reg[0]    <= s_in;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dv_reg[k]    <= dv_reg[k-1];
                dnpos_reg[k] <= dnpos_reg[k-1];
                ds_reg[k]    <= ds_reg[k-1];
            end
        end
    end

    // radicands
    logic [30:0]               q_div;
    logic [31:0]               q_off;
    logic signed [INNER_W-1:0] sx, lx, vx, qx, inner;
    logic signed [X_W-1:0]     bx, ix, xval;
    logic [SQ_ARG_W-1:0]       arg_f_next, arg_c_next;

    always_comb
    begin
        q_div = div_f[DIV_STEPS].quo[30:0];
        q_off = {1'b0, q_div} + 32'(SQRT_OFFSET);
        sx    = INNER_W'(ds_reg[DIV_STEPS-1]);
        lx    = $signed(INNER_W'(length_reg));
        vx    = $signed(INNER_W'({dv_reg[DIV_STEPS-1], 8'b0}));
        qx    = $signed(INNER_W'(div_c[DIV_STEPS].quo));
        inner = ((sx - lx) <<< 17) - vx + qx;
        bx    = $signed(X_W'(est_brake_reg));
        ix    = X_W'(inner);
        xval  = bx * ix + $signed(X_W'(bm2_reg));
        // negative radicand reads as zero
        arg_c_next = xval[X_W-1] ? '0 : SQ_ARG_W'(xval[X_W-2:0]);
        arg_f_next = SQ_ARG_W'({q_off, 16'b0});
    end

    logic [SQ_ARG_W-1:0]  sqa_f [0:SQ_STEPS];
    logic [SQ_ROOT_W-1:0] sqr_f [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]  sqm_f [0:SQ_STEPS];
    logic [SQ_ARG_W-1:0]  sqa_c [0:SQ_STEPS];
    logic [SQ_ROOT_W-1:0] sqr_c [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]  sqm_c [0:SQ_STEPS];
    logic [SQ_ARG_W-1:0]  arg_f_reg, arg_c_reg;
    logic [30:0]          sq_q_reg    [0:SQ_STEPS];
    logic [SPEED_W-1:0]   sv_reg      [0:SQ_STEPS];
    logic [PB-1:0]        snpos_reg   [0:SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            arg_f_reg    <= arg_f_next;
            arg_c_reg    <= arg_c_next;
            sq_q_reg[0]  <= q_div;
            sv_reg[0]    <= dv_reg[DIV_STEPS-1];
            snpos_reg[0] <= dnpos_reg[DIV_STEPS-1];
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_q_reg[k]  <= sq_q_reg[k-1];
                sv_reg[k]    <= sv_reg[k-1];
                snpos_reg[k] <= snpos_reg[k-1];
            end
        end
    end

    assign sqa_f[0] = arg_f_reg;
    assign sqr_f[0] = '0;
    assign sqm_f[0] = '0;
    assign sqa_c[0] = arg_c_reg;
    assign sqr_c[0] = '0;
    assign sqm_c[0] = '0;

    // square root chain
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        gcf_sqrt_cell #(.ARG_W(SQ_ARG_W)) u_sqrt_f (
            .clk(clk), .en(adv),
            .arg_in(sqa_f[k]), .root_in(sqr_f[k]), .rem_in(sqm_f[k]),
            .arg_out(sqa_f[k+1]), .root_out(sqr_f[k+1]), .rem_out(sqm_f[k+1])
        );
        gcf_sqrt_cell #(.ARG_W(SQ_ARG_W)) u_sqrt_c (
            .clk(clk), .en(adv),
            .arg_in(sqa_c[k]), .root_in(sqr_c[k]), .rem_in(sqm_c[k]),
            .arg_out(sqa_c[k+1]), .root_out(sqr_c[k+1]), .rem_out(sqm_c[k+1])
        );
    end

    // first multiply and congested speed
    logic signed [32:0]      d_free;
    logic signed [57:0]      p_free;
    logic signed [VC_W-1:0]  vc;
    logic signed [41:0]      m1_t_reg;
    logic signed [VC_W-17:0] m1_vcong_reg, m2_vcong_reg;
    logic [SPEED_W-1:0]      m1_v_reg, m2_v_reg;
    logic [PB-1:0]           m1_npos_reg, m2_npos_reg;

    always_comb
    begin
        d_free = 33'sd65536 - $signed({2'b00, sq_q_reg[SQ_STEPS]});
        p_free = 58'(d_free) * 58'($signed({1'b0, sqr_f[SQ_STEPS][23:0]}));
        vc     = $signed(VC_W'({sqr_c[SQ_STEPS], 4'b0})) - $signed(VC_W'(bm_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_t_reg     <= p_free[57:16];
            m1_vcong_reg <= vc[VC_W-1:16];
            m1_v_reg     <= sv_reg[SQ_STEPS];
            m1_npos_reg  <= snpos_reg[SQ_STEPS];
        end
    end

    // acceleration increment
    logic signed [57:0] inc;
    logic signed [57:0] m2_inc_reg;

    assign inc = 58'(m1_t_reg) * 58'($signed({1'b0, a5_reg}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_inc_reg   <= inc;
            m2_vcong_reg <= m1_vcong_reg;
            m2_v_reg     <= m1_v_reg;
            m2_npos_reg  <= m1_npos_reg;
        end
    end

    // free speed rounded up, min and clamp
    logic signed [59:0]      vfs, vfree, vcx, pick;
    logic [NEXT_SPEED_W-1:0] speed_next, speed_reg;
    logic [PB-1:0]           pos_reg;

    always_comb
    begin
        vfs   = $signed(60'({m2_v_reg, 17'b0})) + 60'(m2_inc_reg);
        vfree = (vfs + 60'sd33554431) >>> 25;
        vcx   = 60'(m2_vcong_reg);
        pick  = (vfree < vcx) ? vfree : vcx;
        if (pick < 0)
        begin
            speed_next = '0;
        end
        else if (pick > 60'sd127)
        begin
            speed_next = {NEXT_SPEED_W{1'b1}};
        end
        else
        begin
            speed_next = pick[NEXT_SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_reg <= speed_next;
            pos_reg   <= m2_npos_reg;
        end
    end

    assign result.valid         = vld_reg[ST_OUT];
    assign result.new_speed     = speed_reg;
    assign result.next_position = pos_reg;

`ifndef SYNTHESIS
    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[ST_M2]) |=> vld_reg[ST_OUT])
        else $error("beat lost between last stage and result");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("chain moved during a stall");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (div_f[1].den != '0 && div_c[1].den != '0))
        else $error("zero divisor entered the divider chain");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/gipps_car_following_speed_tb.sv =====
// testbench for the gipps car-following speed block: random and directed vehicles, scoreboard check
`default_nettype none
module gipps_car_following_speed_tb;
    import gcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W = 20;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam int ITEMS_PER_PHASE = 275;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [POS_W-1:0]   own_position;
        logic [SPEED_W-1:0] own_speed;
        logic [POS_W-1:0]   leader_position;
        logic [SPEED_W-1:0] leader_speed;
        logic [SPEED_W-1:0] speed_limit;
    } vehicle_t;

    typedef struct {
        logic [NEXT_SPEED_W-1:0] new_speed;
        logic [POS_W-1:0]        next_position;
    } step_t;

    class speed_scoreboard;
        longint accel, est_brake, own_brake, veh_len, margin;
        step_t  pending_results[$];
        int     errors;

        function new();
            accel     = ACCEL_RESET;
            est_brake = EST_BRAKE_RESET;
            own_brake = OWN_BRAKE_RESET;
            veh_len   = LENGTH_RESET;
            margin    = MARGIN_RESET;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ACCEL:     accel     = data;
                CFG_EST_BRAKE: est_brake = data;
                CFG_OWN_BRAKE: own_brake = data;
                CFG_LENGTH:    veh_len   = data[LENGTH_W-1:0];
                CFG_MARGIN:    margin    = data[MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function step_t next_step(vehicle_t veh);
            longint unsigned v, vl, vm, b0, q, sq, y, npos;
            longint d, inc, vf, vfree, bm, s, inner, x, vc, vcong, res;
            step_t st;
            v  = veh.own_speed;
            vl = veh.leader_speed;
            vm = (veh.speed_limit == 0) ? 1 : veh.speed_limit;
            b0 = (own_brake == 0) ? 1 : own_brake;

            // free-flow term, rounded up
            q     = (v << 16) / vm;
            d     = 65536 - longint'(q);
            sq    = int_sqrt((q + SQRT_OFFSET) << 16);
            inc   = ((d * longint'(sq)) >>> 16) * (5 * accel);
            vf    = longint'(v << (25 - SPEED_FRAC_BITS)) + inc;
            vfree = -((-vf) >>> 25);

            // congested term, rounded down
            bm    = est_brake * margin;
            s     = longint'(veh.leader_position) - longint'(veh.own_position);
            inner = (s - veh_len) * 131072 - longint'(v << (16 - SPEED_FRAC_BITS))
                  + longint'((((vl * vl) << 24) / b0) >> (2 * SPEED_FRAC_BITS));
            x     = ((bm * bm) >>> 8) + est_brake * inner;
            if (x < 0)
                x = 0;
            y     = int_sqrt(longint'(x));
            vc    = longint'(y << 4) - bm;
            vcong = vc >>> 16;

            res = (vfree < vcong) ? vfree : vcong;
            if (res < 0)
                res = 0;
            if (res > 127)
                res = 127;
            npos = longint'(veh.own_position) + (v >> SPEED_FRAC_BITS);
            if (npos > POS_MAX)
                npos = POS_MAX;
            st.new_speed     = res[NEXT_SPEED_W-1:0];
            st.next_position = npos[POS_W-1:0];
            return st;
        endfunction

        function void note_vehicle(vehicle_t veh);
            pending_results.push_back(next_step(veh));
        endfunction

        task report(string what, longint got, longint want);
            $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [NEXT_SPEED_W-1:0] spd, logic [POS_W-1:0] pos);
            step_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected result beat, new_speed", spd, -1);
                return;
            end
            want = pending_results.pop_front();
            if (spd !== want.new_speed)
                report("new_speed", spd, want.new_speed);
            if (pos !== want.next_position)
                report("next_position", pos, want.next_position);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int send_idle;
    int recv_idle;
    int sent;
    speed_scoreboard sb;

    gcf_vehicle_if #(.POSITION_BITS(POS_W)) veh_ch ();
    gcf_result_if  #(.POSITION_BITS(POS_W)) res_ch ();

    gipps_car_following_speed #(.POSITION_BITS(POS_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vehicle   (veh_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.new_speed, res_ch.next_position);
    end

    task set_idle_mode();
        if (sent < 550)
        begin
            send_idle = 36;
            recv_idle = 81;
        end
        else if (sent < 1100)
        begin
            send_idle = 81;
            recv_idle = 36;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task send_vehicle(vehicle_t veh);
        set_idle_mode();
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            veh_ch.valid <= 1'b0;
            @(negedge clk);
        end
        veh_ch.own_position    <= veh.own_position;
        veh_ch.own_speed       <= veh.own_speed;
        veh_ch.leader_position <= veh.leader_position;
        veh_ch.leader_speed    <= veh.leader_speed;
        veh_ch.speed_limit     <= veh.speed_limit;
        veh_ch.valid           <= 1'b1;
        do
            @(posedge clk);
        while (!veh_ch.ready);
        sb.note_vehicle(veh);
        sent++;
    endtask

    task send_fields(logic [POS_W-1:0] op, logic [SPEED_W-1:0] v, logic [POS_W-1:0] lp,
                     logic [SPEED_W-1:0] vl, logic [SPEED_W-1:0] vm);
        vehicle_t veh;
        veh = '{op, v, lp, vl, vm};
        send_vehicle(veh);
    endtask

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task drain();
        @(negedge clk);
        veh_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task random_vehicles(int n);
        vehicle_t veh;
        int gap;
        repeat (n)
        begin
            if ($urandom_range(99) < 20)
            begin
                // noise over the whole field range
                veh.own_position    = POS_W'($urandom());
                veh.own_speed       = SPEED_W'($urandom());
                veh.leader_position = POS_W'($urandom());
                veh.leader_speed    = SPEED_W'($urandom());
                veh.speed_limit     = SPEED_W'($urandom());
            end
            else
            begin
                // plausible traffic: leader a little ahead, road speeds
                gap = $urandom_range(300);
                veh.own_position    = POS_W'($urandom());
                veh.leader_position = veh.own_position + POS_W'(gap);
                veh.own_speed       = SPEED_W'($urandom_range(45 << 8));
                veh.leader_speed    = SPEED_W'($urandom_range(45 << 8));
                veh.speed_limit     = SPEED_W'($urandom_range(15 << 8, 45 << 8));
            end
            send_vehicle(veh);
        end
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ACCEL;
        cfg_data = '0;
        veh_ch.valid = 1'b0;
        veh_ch.own_position = '0;
        veh_ch.own_speed = '0;
        veh_ch.leader_position = '0;
        veh_ch.leader_speed = '0;
        veh_ch.speed_limit = '0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed vehicles at the reset settings
        send_fields('0, '0, '0, '0, '0);
        send_fields(POS_MAX, SPEED_MAX, POS_MAX, SPEED_MAX, SPEED_MAX);
        send_fields(POS_MAX, SPEED_MAX, '0, '0, SPEED_MAX);
        send_fields(20'd100, 15'h1400, 20'd150, 15'h1400, 15'h1e00);
        send_fields('0, SPEED_MAX, 20'd1000, '0, 15'd1);
        send_fields(20'd5000, 15'h0a00, 20'd4990, 15'h0a00, 15'h2000);
        send_fields('0, 15'h7f00, POS_MAX, SPEED_MAX, SPEED_MAX);
        send_fields(20'd300, '0, 20'd1300, SPEED_MAX, 15'h1e00);
        send_fields(20'd300, 15'h0800, 20'd300, '0, '0);
        send_fields(20'd42, 15'h00ff, 20'd49, 15'h00ff, 15'h0100);
        send_fields(POS_MAX - 20'd3, 15'h05ff, POS_MAX, 15'h2000, 15'h2000);
        send_fields(20'h55555, 15'h2aaa, 20'haaaaa, 15'h5555, 15'h2aaa);
        send_fields('0, '0, 20'd10000, '0, 15'd1);
        random_vehicles(ITEMS_PER_PHASE - 13);
        drain();

        for (int phase = 1; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(CFG_ACCEL, 12'd4095);
                    write_reg(CFG_EST_BRAKE, 12'd4095);
                    write_reg(CFG_OWN_BRAKE, 12'd4095);
                    write_reg(CFG_LENGTH, 12'd255);
                    write_reg(CFG_MARGIN, 12'd1023);
                end
                2:
                begin
                    write_reg(CFG_ACCEL, 12'd0);
                    write_reg(CFG_EST_BRAKE, 12'd0);
                    write_reg(CFG_OWN_BRAKE, 12'd0);
                    write_reg(CFG_LENGTH, 12'd0);
                    write_reg(CFG_MARGIN, 12'd0);
                end
                3:
                begin
                    write_reg(CFG_ACCEL, 12'd1);
                    write_reg(CFG_EST_BRAKE, 12'd1);
                    write_reg(CFG_OWN_BRAKE, 12'd1);
                    write_reg(CFG_LENGTH, 12'd7);
                    write_reg(CFG_MARGIN, 12'd256);
                    // writes past the last register must change nothing
                    for (int i = CFG_MARGIN + 1; i < (1 << CFG_INDEX_W); i++)
                        write_reg(CFG_INDEX_W'(i), 12'($urandom()));
                end
                default:
                begin
                    write_reg(CFG_ACCEL, 12'($urandom_range(1, 4095)));
                    write_reg(CFG_EST_BRAKE, 12'($urandom_range(1, 4095)));
                    write_reg(CFG_OWN_BRAKE, 12'($urandom_range(1, 4095)));
                    write_reg(CFG_LENGTH, 12'($urandom_range(255)));
                    write_reg(CFG_MARGIN, 12'($urandom_range(1023)));
                end
            endcase
            end_writes();
            random_vehicles(ITEMS_PER_PHASE);
            drain();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("gipps_car_following_speed_tb: done, clean");
        else
            $display("gipps_car_following_speed_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("gipps_car_following_speed_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
